### rtl/core/sum_checked_frame_scanner_macros.svh
// ----------------------------------------------------------------------------
// Frame scanner assertion macros
// Clocked assertion forms used by the port level checker file.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_SCANNER_MACROS_SVH
`define SUM_CHECKED_FRAME_SCANNER_MACROS_SVH

// assert a property on the rising clock edge, off while in reset
`define SCFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assert a property on the rising clock edge, during reset too
`define SCFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scfs_pkg.sv
// ----------------------------------------------------------------------------
// Frame scanner package
// Request and result types, marker constants and scan states.
// ----------------------------------------------------------------------------
package scfs_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 255;
  localparam logic [7:0]  START_MARK       = 8'h0C;
  localparam logic [7:0]  END_MARK         = 8'h0D;
  localparam int unsigned MIN_SCAN_LEN     = 5;
  localparam logic [6:0]  MAX_FRAMES       = 7'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       link_known;
  } scfs_req_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] command;
    logic [7:0] frame_offset;
    logic [7:0] payload_size;
    logic [6:0] frame_count;
    logic       overflowed;
    logic       last;
  } scfs_rsp_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_START,
    ST_SIZE,
    ST_END,
    ST_SUM,
    ST_EMIT,
    ST_SUMMARY
  } scfs_state_e;

endpackage

### rtl/core/scfs_ram.sv
// ----------------------------------------------------------------------------
// Frame scanner RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module scfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 255
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sum_checked_frame_scanner.sv
// ----------------------------------------------------------------------------
// Sum checked frame scanner
// Buffers one packet, then scans it for 0x0C/size/body/sum/0x0D frames.
// ----------------------------------------------------------------------------
//   channel   dir  handshake                 payload
//   request   in   req_valid_i / req_stall_o scfs_req_t  req_i
//   result    out  rsp_valid_o / rsp_stall_i scfs_rsp_t  rsp_o
//
// Loading takes one request byte per cycle; the store write port sets that rate.
// The scan walks the store through its single read port, byte by byte past
// bytes that are no start mark and frame by frame past valid frames.
// Requests are stalled from the last byte until the summary result is loaded.
// Reset clears byte count, overflow flag, state and result valid; the store
// needs no clearing, as only bytes of the current packet are read.
// A stalled result holds in the output register; the scan goes on until it has the next result.
// ----------------------------------------------------------------------------
module sum_checked_frame_scanner #(
  parameter int unsigned BUFFER_BYTES = scfs_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  scfs_pkg::scfs_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output scfs_pkg::scfs_rsp_t rsp_o
);

  import scfs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned EXT_W  = ((CNT_W > 8) ? CNT_W : 8) + 2;

  scfs_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  end_q, end_d;
  logic [CNT_W-1:0]  cur_q, cur_d;
  logic [7:0]        size_q, size_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [6:0]        found_q, found_d;
  scfs_rsp_t         rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              req_acc;
  logic              room;
  logic [CNT_W-1:0]  new_count;
  logic              new_ovf;
  logic              scan_ok;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  pos_two;
  logic [CNT_W-1:0]  pos_three;
  logic              near_end;
  logic [EXT_W-1:0]  frame_end;
  logic              past_end;
  logic              rsp_free;
  logic              is_start;
  logic              sum_byte;
  logic              cap_full;

  scfs_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.data_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_acc   = req_valid_i && !req_stall_o;
  assign room      = count_q < CNT_W'(BUFFER_BYTES);
  assign new_count = room ? count_q + CNT_W'(1) : count_q;
  assign new_ovf   = ovf_q || !room;
  assign scan_ok   = (new_count > CNT_W'(MIN_SCAN_LEN)) && req_i.link_known;
  assign pos_inc   = pos_q + CNT_W'(1);
  assign pos_two   = pos_q + CNT_W'(2);
  assign pos_three = pos_q + CNT_W'(3);
  assign near_end  = ({1'b0, pos_q} + (CNT_W + 1)'(4)) >= {1'b0, count_q};
  assign frame_end = EXT_W'(pos_q) + EXT_W'(3) + EXT_W'(ram_rdata);
  assign past_end  = frame_end >= EXT_W'(count_q);
  assign rsp_free  = !rsp_valid_q || !rsp_stall_i;
  assign is_start  = ram_rdata == START_MARK;
  assign sum_byte  = cur_q == (end_q - CNT_W'(1));
  assign cap_full  = found_q == MAX_FRAMES;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (req_acc && req_i.last_byte) begin
          state_d = scan_ok ? ST_FETCH : ST_SUMMARY;
        end
      end
      ST_FETCH: begin
        state_d = (pos_q >= count_q) ? ST_SUMMARY : ST_START;
      end
      ST_START: begin
        if (!is_start) begin
          state_d = (pos_inc >= count_q) ? ST_SUMMARY : ST_START;
        end else begin
          state_d = near_end ? ST_SUMMARY : ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_d = past_end ? ST_FETCH : ST_END;
      end
      ST_END: begin
        state_d = (ram_rdata == END_MARK) ? ST_SUM : ST_FETCH;
      end
      ST_SUM: begin
        if (sum_byte) begin
          state_d = (ram_rdata == sum_q) ? ST_EMIT : ST_FETCH;
        end
      end
      ST_EMIT: begin
        if (cap_full || rsp_free) begin
          state_d = ST_FETCH;
        end
      end
      ST_SUMMARY: begin
        if (rsp_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath and result register
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    end_d       = end_q;
    cur_d       = cur_q;
    size_d      = size_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    found_d     = found_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    unique case (state_q)
      ST_LOAD: begin
        if (req_acc) begin
          count_d = new_count;
          ovf_d   = new_ovf;
          pos_d   = '0;
          found_d = '0;
        end
      end
      ST_START: begin
        if (!is_start) begin
          pos_d = pos_inc;
        end
      end
      ST_SIZE: begin
        size_d = ram_rdata;
        sum_d  = ram_rdata;
        end_d  = frame_end[CNT_W-1:0];
        if (past_end) begin
          pos_d = pos_inc;
        end
      end
      ST_END: begin
        cur_d = pos_two;
        cmd_d = ram_rdata;
        if (ram_rdata != END_MARK) begin
          pos_d = pos_inc;
        end
      end
      ST_SUM: begin
        if (cur_q == pos_three) begin
          cmd_d = ram_rdata;
        end
        if (sum_byte) begin
          if (ram_rdata != sum_q) begin
            pos_d = pos_inc;
          end
        end else begin
          sum_d = sum_q + ram_rdata;
          cur_d = cur_q + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (cap_full) begin
          pos_d = end_q + CNT_W'(1);
        end else if (rsp_free) begin
          pos_d              = end_q + CNT_W'(1);
          found_d            = found_q + 7'd1;
          rsp_valid_d        = 1'b1;
          rsp_d.frame_valid  = 1'b1;
          rsp_d.command      = cmd_q;
          rsp_d.frame_offset = 8'(pos_q);
          rsp_d.payload_size = size_q;
          rsp_d.frame_count  = '0;
          rsp_d.overflowed   = ovf_q;
          rsp_d.last         = 1'b0;
        end
      end
      ST_SUMMARY: begin
        if (rsp_free) begin
          count_d            = '0;
          ovf_d              = 1'b0;
          rsp_valid_d        = 1'b1;
          rsp_d.frame_valid  = 1'b0;
          rsp_d.command      = '0;
          rsp_d.frame_offset = '0;
          rsp_d.payload_size = '0;
          rsp_d.frame_count  = found_q;
          rsp_d.overflowed   = ovf_q;
          rsp_d.last         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // outputs and store ports
  always_comb begin
    req_stall_o = state_q != ST_LOAD;
    ram_we      = (state_q == ST_LOAD) && req_acc && room;
    ram_waddr   = count_q[ADDR_W-1:0];
    ram_raddr   = pos_q[ADDR_W-1:0];
    unique case (state_q)
      ST_START: ram_raddr = pos_inc[ADDR_W-1:0];
      ST_SIZE:  ram_raddr = frame_end[ADDR_W-1:0];
      ST_END:   ram_raddr = pos_two[ADDR_W-1:0];
      ST_SUM:   ram_raddr = ADDR_W'(cur_q + CNT_W'(1));
      default:  ram_raddr = pos_q[ADDR_W-1:0];
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      found_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q  <= end_d;
    cur_q  <= cur_d;
    size_q <= size_d;
    sum_q  <= sum_d;
    cmd_q  <= cmd_d;
    rsp_q  <= rsp_d;
  end

endmodule

### rtl/core/scfs_checker.sv
// ----------------------------------------------------------------------------
// Frame scanner checker
// Port level checks on the frame scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_scanner_macros.svh"

module scfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_stall_i,
  input scfs_pkg::scfs_req_t req_i,
  input logic                rsp_valid_i,
  input logic                rsp_stall_i,
  input scfs_pkg::scfs_rsp_t rsp_i
);

  import scfs_pkg::*;

  `SCFS_ASSERT(a_last_is_summary, clk_i, rst_ni, rsp_valid_i |-> (rsp_i.last == !rsp_i.frame_valid), "last flag disagrees with frame flag")

  `SCFS_ASSERT(a_summary_clean, clk_i, rst_ni, (rsp_valid_i && rsp_i.last) |-> (rsp_i.command == 8'd0 && rsp_i.frame_offset == 8'd0 && rsp_i.payload_size == 8'd0), "summary result carries frame fields")

  `SCFS_ASSERT(a_frame_fits, clk_i, rst_ni, (rsp_valid_i && rsp_i.frame_valid) |-> ((10'(rsp_i.frame_offset) + 10'(rsp_i.payload_size) + 10'd3) < 10'd255), "frame reaches past the store")

  `SCFS_ASSERT(a_scan_stalls, clk_i, rst_ni, (req_valid_i && !req_stall_i && req_i.last_byte) |=> req_stall_i, "request taken during scan")

  `SCFS_ASSERT(a_rsp_hold, clk_i, rst_ni, (rsp_valid_i && rsp_stall_i) |=> (rsp_valid_i && $stable(rsp_i)), "stalled result changed")

endmodule

bind sum_checked_frame_scanner scfs_checker u_scfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_i (req_stall_o),
  .req_i       (req_i),
  .rsp_valid_i (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_i       (rsp_o)
);

### tb/sv/scfs_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scanner result checker
// Watches both channels and mirrors the packet store and frame scan. It queues
// the results each last byte should give and compares every accepted result,
// field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module scfs_frame_checker
  import scfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  scfs_req_t   req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_stall_i,
  input  scfs_rsp_t   rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int unsigned STORE_DEPTH  = BUFFER_BYTES_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [7:0]  packet_bytes [STORE_DEPTH];
  int unsigned packet_len;
  logic        packet_dropped;
  int unsigned mismatches;
  scfs_rsp_t   frame_results_q [$];

  function automatic string describe_result(input scfs_rsp_t r);
    return $sformatf("valid=%0b cmd=%0d off=%0d size=%0d count=%0d ovf=%0b last=%0b",
                     r.frame_valid, r.command, r.frame_offset, r.payload_size,
                     r.frame_count, r.overflowed, r.last);
  endfunction

  function automatic void scan_packet(input logic link);
    int unsigned pos;
    int unsigned size;
    int unsigned idx;
    int unsigned found;
    logic [7:0]  total;
    scfs_rsp_t   rsp;
    found = 0;
    if (packet_len > MIN_SCAN_LEN && link) begin
      for (pos = 0; pos < packet_len; pos++) begin
        if (packet_bytes[pos] != START_MARK) continue;
        if (pos + 4 >= packet_len) break;
        size = packet_bytes[pos + 1];
        if (pos + 3 + size >= packet_len) continue;
        if (packet_bytes[pos + 3 + size] != END_MARK) continue;
        total = '0;
        for (idx = 0; idx <= size; idx++) total += packet_bytes[pos + 1 + idx];
        if (total != packet_bytes[pos + 2 + size]) continue;
        if (found < MAX_FRAMES) begin
          rsp              = '0;
          rsp.frame_valid  = 1'b1;
          rsp.command      = packet_bytes[pos + 3];
          rsp.frame_offset = 8'(pos);
          rsp.payload_size = 8'(size);
          rsp.overflowed   = packet_dropped;
          frame_results_q.push_back(rsp);
          found++;
        end
        pos += size + 3;
      end
    end
    rsp             = '0;
    rsp.frame_count = 7'(found);
    rsp.overflowed  = packet_dropped;
    rsp.last        = 1'b1;
    frame_results_q.push_back(rsp);
    packet_len     = 0;
    packet_dropped = 1'b0;
  endfunction

  function automatic void check_result(input scfs_rsp_t got);
    scfs_rsp_t want;
    if (frame_results_q.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result with none expected: %s", $realtime, describe_result(got));
      mismatches++;
    end else begin
      want = frame_results_q.pop_front();
      if (got.frame_valid !== want.frame_valid || got.command !== want.command ||
          got.frame_offset !== want.frame_offset ||
          got.payload_size !== want.payload_size ||
          got.frame_count !== want.frame_count || got.overflowed !== want.overflowed ||
          got.last !== want.last) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                   describe_result(want), describe_result(got));
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_len     = 0;
      packet_dropped = 1'b0;
      mismatches     = 0;
      frame_results_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) check_result(rsp_i);
      if (req_valid_i && !req_stall_i) begin
        if (packet_len < STORE_DEPTH) begin
          packet_bytes[packet_len] = req_i.data_byte;
          packet_len++;
        end else begin
          packet_dropped = 1'b1;
        end
        if (req_i.last_byte) scan_packet(req_i.link_known);
      end
      mismatch_count_o <= mismatches;
      pending_o        <= frame_results_q.size();
    end
  end

endmodule

### tb/sv/tb_sum_checked_frame_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scanner testbench
// Sends directed packets (short, unknown link, failed checks, nested frames,
// most frames, full store, overflow) and then random packets built mostly
// from well-formed frames, first with random idling on both channels. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sum_checked_frame_scanner;
  import scfs_pkg::*;

  localparam int unsigned TARGET_BYTES   = 370;
  localparam int unsigned TAIL_BYTES     = 80;
  localparam int unsigned QUIET_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 50;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END} frame_flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_stall_o;
  scfs_req_t   req_i;
  logic        rsp_valid_o;
  logic        rsp_stall_i;
  scfs_rsp_t   rsp_o;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  bit          idling = 1'b1;
  logic [7:0]  pkt [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sum_checked_frame_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  scfs_frame_checker frame_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid_i),
    .req_stall_i      (req_stall_o),
    .req_i            (req_i),
    .rsp_valid_i      (rsp_valid_o),
    .rsp_stall_i      (rsp_stall_i),
    .rsp_i            (rsp_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rsp_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idling && $urandom_range(0, 5) == 0) begin
        rsp_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        rsp_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return START_MARK;
    if (pick == 2) return END_MARK;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned random_size();
    int unsigned band;
    band = $urandom_range(0, 99);
    if (band < 75) return $urandom_range(0, 10);
    if (band < 95) return $urandom_range(11, 40);
    return $urandom_range(41, 251);
  endfunction

  function automatic void wrap_as_frame(input int unsigned start_idx);
    logic [7:0]  size;
    logic [7:0]  total;
    int unsigned idx;
    size  = 8'(pkt.size() - start_idx);
    total = size;
    for (idx = start_idx; idx < pkt.size(); idx++) total += pkt[idx];
    pkt.insert(start_idx, size);
    pkt.insert(start_idx, START_MARK);
    pkt.push_back(total);
    pkt.push_back(END_MARK);
  endfunction

  function automatic void add_frame(input int unsigned size, input logic [7:0] cmd,
                                    input frame_flaw_e flaw);
    int unsigned start_idx;
    int unsigned idx;
    start_idx = pkt.size();
    for (idx = 0; idx < size; idx++) pkt.push_back(idx == 1 ? cmd : rand_byte());
    wrap_as_frame(start_idx);
    if (flaw == FRAME_BAD_SUM)
      pkt[pkt.size() - 2] += 8'($urandom_range(1, 255));
    else if (flaw == FRAME_BAD_END)
      pkt[pkt.size() - 1] = END_MARK ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic void build_random_packet();
    int unsigned band;
    int unsigned target;
    int unsigned pick;
    band = $urandom_range(0, 99);
    if (band < 55)      target = $urandom_range(1, 16);
    else if (band < 88) target = $urandom_range(17, 60);
    else if (band < 98) target = $urandom_range(61, 255);
    else                target = $urandom_range(256, 262);
    while (pkt.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      add_frame(random_size(), rand_byte(), FRAME_GOOD);
      else if (pick < 70) add_frame(random_size(), rand_byte(), FRAME_BAD_SUM);
      else if (pick < 80) add_frame(random_size(), rand_byte(), FRAME_BAD_END);
      else repeat ($urandom_range(1, 4)) pkt.push_back(rand_byte());
    end
    if ($urandom_range(0, 2) == 0) target = pkt.size();
    if (target < pkt.size() - 0 && $urandom_range(0, 1) == 0) target = pkt.size();
    if (target > 262) target = 262;
    while (pkt.size() > target) void'(pkt.pop_back());
  endfunction

  task automatic push_request(input scfs_req_t r);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (req_stall_o !== 1'b0);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic link);
    scfs_req_t   r;
    int unsigned idx;
    for (idx = 0; idx < pkt.size(); idx++) begin
      r.data_byte  = pkt[idx];
      r.last_byte  = (idx == pkt.size() - 1);
      r.link_known = r.last_byte ? link : 1'($urandom_range(0, 1));
      push_request(r);
    end
    pkt.delete();
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned start_idx;
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pkt.push_back(8'h00);
    send_packet(1'b1);

    // too short to scan, though it holds a frame
    add_frame(0, 8'h00, FRAME_GOOD);
    pkt.push_back(8'hFF);
    send_packet(1'b1);

    add_frame(0, 8'h00, FRAME_GOOD);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    send_packet(1'b1);

    add_frame(0, 8'h00, FRAME_GOOD);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    send_packet(1'b0);

    // failed checks, a frame hidden in a good one, one in a failed one,
    // then a start mark too near the end
    add_frame(2, 8'hFF, FRAME_GOOD);
    add_frame(3, 8'h00, FRAME_BAD_SUM);
    add_frame(1, 8'h5A, FRAME_BAD_END);
    start_idx = pkt.size();
    add_frame(0, 8'h00, FRAME_GOOD);
    pkt.push_back(8'h55);
    wrap_as_frame(start_idx);
    start_idx = pkt.size();
    add_frame(2, 8'h11, FRAME_GOOD);
    pkt.push_back(8'hAA);
    wrap_as_frame(start_idx);
    pkt[pkt.size() - 2] += 8'h01;
    pkt.push_back(8'hFF);
    pkt.push_back(START_MARK);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    send_packet(1'b1);

    // frame running past the end, then a short one that fits
    pkt = {START_MARK, 8'h20, 8'h01, 8'h02, START_MARK, 8'h00, 8'h00, END_MARK, 8'h00};
    send_packet(1'b1);

    // most frames the store holds, and the last byte finds it full
    repeat (63) add_frame(0, 8'h00, FRAME_GOOD);
    repeat (4) pkt.push_back(8'hFF);
    send_packet(1'b1);

    // hold until every result is back
    req_valid_i <= 1'b0;
    drain_results();

    while (bytes_sent + TAIL_BYTES < TARGET_BYTES) begin
      build_random_packet();
      send_packet($urandom_range(0, 9) != 0);
    end

    idling = 1'b0;
    while (bytes_sent < TARGET_BYTES) begin
      build_random_packet();
      send_packet($urandom_range(0, 9) != 0);
    end
    req_valid_i <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
